@@ rtl/core/bitmap_block_allocator_top_macros.svh @@
// Assertion macros for the bitmap block allocator RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bba_pkg.sv @@
// Package for the bitmap block allocator: payload structs, codes and helpers.
// No dependencies; used by bba_regs and bitmap_block_allocator_top.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int unsigned NBLOCKS_DEF = 65536;
  localparam int unsigned WORD_W      = 32;

  localparam logic [16:0] TOTAL_RST = 17'd65536;
  localparam logic [16:0] META_RST  = 17'd0;

  // Register select, taken from address bit 2.
  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_META  = 1'b1;

  typedef enum logic [2:0] {
    OP_FORMAT  = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_RELEASE = 3'd2,
    OP_TEST    = 3'd3,
    OP_RAW     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_RANGE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_AL_SUM,
    ST_AL_MAP,
    ST_RMW
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] block_index;
    logic        bit_value;
  } bba_in_t;

  typedef struct packed {
    logic [15:0] result_block;
    logic        bit_read;
    logic [16:0] free_count;
    status_e     status;
  } bba_out_t;

  typedef struct packed {
    logic [16:0] total;
    logic [16:0] meta;
  } cfg_t;

  // Ones in every bit position p of unit 'unit' with unit*32 + p < cnt.
  function automatic logic [31:0] fill_mask(input logic [16:0] unit, input logic [16:0] cnt);
    logic [31:0] m;
    m = '0;
    if (unit < (cnt >> 5)) begin
      m = '1;
    end else if (unit == (cnt >> 5)) begin
      m = (32'd1 << cnt[4:0]) - 32'd1;
    end
    return m;
  endfunction

  // Lowest clear bit of a word: {found, index}.
  function automatic logic [5:0] ffz32(input logic [31:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) begin
        r = {1'b1, 5'(i)};
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/bba_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/bba_regs.sv @@
// APB-style configuration registers of the bitmap block allocator.
// Depends on bba_pkg for the register selects, reset values and cfg_t.
`timescale 1ns / 1ps

module bba_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output bba_pkg::cfg_t cfg_o
);
  import bba_pkg::*;

  logic [16:0] total_q, total_d;
  logic [16:0] meta_q, meta_d;
  logic        wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    total_d = total_q;
    meta_d  = meta_q;
    if (wr_en) begin
      case (paddr[2])
        REG_TOTAL: total_d = pwdata[16:0];
        REG_META:  meta_d  = pwdata[16:0];
        default:   total_d = total_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOTAL: prdata = {15'd0, total_q};
      REG_META:  prdata = {15'd0, meta_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RST;
      meta_q  <= META_RST;
    end else begin
      total_q <= total_d;
      meta_q  <= meta_d;
    end
  end

  assign cfg_o = '{total: total_q, meta: meta_q};

endmodule

@@ rtl/core/bitmap_block_allocator_top.sv @@
// Allocate takes the summary probe (ST_AL_SUM), then the map probe (ST_AL_MAP); release,
// test and raw write take ST_RMW; rejected or undefined items are answered from idle;
// format sweeps the map, one map word written per cycle. One item at a time; while one
// is in work, busy stays high until the result strobe, which the receiver cannot stall;
// the next item may start in the cycle the result is shown. Reset sweeps the map and its
// summaries clear with busy high; the free count resets to zero, config writes stay open.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_top_macros.svh"

module bitmap_block_allocator_top #(
  parameter int unsigned NBLOCKS = bba_pkg::NBLOCKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bba_pkg::bba_in_t  item_i,
  output logic              done_o,
  output bba_pkg::bba_out_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import bba_pkg::*;

  // Block totals never exceed 17 bits, so the map stops there.
  localparam int unsigned MapBits   = (NBLOCKS > 131072) ? 131072 : NBLOCKS;
  localparam int unsigned WordsMin  = (MapBits + WORD_W - 1) / WORD_W;
  localparam int unsigned SumRaw    = (WordsMin + WORD_W - 1) / WORD_W;
  localparam int unsigned SumWords  = (SumRaw < 2) ? 2 : SumRaw;
  localparam int unsigned MapWords  = SumWords * WORD_W;
  localparam int unsigned WordAw    = $clog2(MapWords);
  localparam int unsigned SumAw     = $clog2(SumWords);

  cfg_t cfg;

  bba_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Map RAM: one bit per block. Summary RAM: one full flag per map word.
  // top_q: one full flag per summary word.
  logic              map_we, sum_we;
  logic [WordAw-1:0] map_waddr, map_raddr;
  logic [SumAw-1:0]  sum_waddr, sum_raddr;
  logic [31:0]       map_wdata, map_rdata, sum_wdata, sum_rdata;

  bba_ram #(.WIDTH(WORD_W), .DEPTH(MapWords)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bba_ram #(.WIDTH(WORD_W), .DEPTH(SumWords)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  state_e            state_q, state_d;
  logic [WordAw-1:0] sweep_q, sweep_d;
  logic [16:0]       sweep_meta_q, sweep_meta_d;
  logic              fmt_q, fmt_d;
  logic [16:0]       count_q, count_d;
  logic [SumWords-1:0] top_q, top_d;
  logic              done_q, done_d;
  bba_out_t          res_q, res_d;
  op_e               op_q, op_d;
  logic [15:0]       idx_q, idx_d;
  logic              bv_q, bv_d;
  logic [WordAw-1:0] word_adr_q, word_adr_d;
  logic [SumAw-1:0]  sum_adr_q, sum_adr_d;
  logic [31:0]       sum_word_q, sum_word_d;

  logic [16:0]       total, meta;
  logic              accept, idx_bad, sweep_last;
  logic [31:0]       idx_ext;
  logic              top_found;
  logic [SumAw-1:0]  top_idx;
  logic [5:0]        j_res, b_res;
  logic [WordAw+4:0] pick;
  logic [31:0]       alloc_word, rmw_word, alloc_sum, rmw_sum;
  logic [SumAw-1:0]  sweep_unit;

  assign total = (32'(cfg.total) > NBLOCKS) ? 17'(NBLOCKS) : cfg.total;
  assign meta  = (cfg.meta > total) ? total : cfg.meta;

  assign accept     = start && !busy;
  assign idx_ext    = 32'(item_i.block_index);
  assign idx_bad    = {1'b0, item_i.block_index} >= total;
  assign sweep_last = sweep_q == WordAw'(MapWords - 1);
  assign sweep_unit = sweep_q[WordAw-1:5];

  // First summary word that still has a non-full map word.
  always_comb begin
    top_found = 1'b0;
    top_idx   = '0;
    for (int i = SumWords - 1; i >= 0; i--) begin
      if (!top_q[i]) begin
        top_found = 1'b1;
        top_idx   = SumAw'(i);
      end
    end
  end

  assign j_res = ffz32(sum_rdata);
  assign b_res = ffz32(map_rdata);
  assign pick  = {word_adr_q, b_res[4:0]};

  always_comb begin
    alloc_word = map_rdata | (32'd1 << b_res[4:0]);
    alloc_sum  = sum_word_q;
    alloc_sum[word_adr_q[4:0]] = &alloc_word;
  end

  always_comb begin
    rmw_word = map_rdata;
    rmw_word[idx_q[4:0]] = (op_q == OP_RAW) ? bv_q : 1'b0;
    rmw_sum  = sum_rdata;
    rmw_sum[idx_q[9:5]] = &rmw_word;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(item_i.opcode))
            OP_FORMAT: state_d = ST_SWEEP;
            OP_ALLOC: begin
              if (count_q != '0 && top_found) state_d = ST_AL_SUM;
            end
            OP_RELEASE, OP_TEST, OP_RAW: begin
              if (!idx_bad) state_d = ST_RMW;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_AL_SUM: state_d = j_res[5] ? ST_AL_MAP : ST_IDLE;
      ST_AL_MAP: state_d = ST_IDLE;
      ST_RMW:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory control and datapath.
  always_comb begin
    map_we       = 1'b0;
    map_waddr    = word_adr_q;
    map_wdata    = alloc_word;
    map_raddr    = word_adr_q;
    sum_we       = 1'b0;
    sum_waddr    = sum_adr_q;
    sum_wdata    = alloc_sum;
    sum_raddr    = sum_adr_q;
    sweep_d      = sweep_q;
    sweep_meta_d = sweep_meta_q;
    fmt_d        = fmt_q;
    count_d      = count_q;
    top_d        = top_q;
    done_d       = 1'b0;
    res_d        = res_q;
    op_d         = op_q;
    idx_d        = idx_q;
    bv_d         = bv_q;
    word_adr_d   = word_adr_q;
    sum_adr_d    = sum_adr_q;
    sum_word_d   = sum_word_q;

    case (state_q)
      ST_SWEEP: begin
        map_we    = 1'b1;
        map_waddr = sweep_q;
        map_wdata = fill_mask(17'(sweep_q), sweep_meta_q);
        if (sweep_q[4:0] == 5'd0) begin
          sum_we    = 1'b1;
          sum_waddr = sweep_unit;
          sum_wdata = fill_mask(17'(sweep_unit), sweep_meta_q >> 5);
          top_d[sweep_unit] = 17'(sweep_unit) < (sweep_meta_q >> 10);
        end
        sweep_d = sweep_q + WordAw'(1);
        if (sweep_last && fmt_q) begin
          done_d = 1'b1;
          res_d  = '{result_block: '0, bit_read: 1'b0, free_count: count_q, status: STAT_OK};
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_d  = op_e'(item_i.opcode);
          idx_d = item_i.block_index;
          bv_d  = item_i.bit_value;
          res_d = '{result_block: '0, bit_read: 1'b0, free_count: count_q, status: STAT_OK};
          case (op_e'(item_i.opcode))
            OP_FORMAT: begin
              sweep_d      = '0;
              sweep_meta_d = meta;
              fmt_d        = 1'b1;
              count_d      = total - meta;
            end
            OP_ALLOC: begin
              if (count_q != '0 && top_found) begin
                sum_raddr = top_idx;
                sum_adr_d = top_idx;
              end else begin
                done_d       = 1'b1;
                res_d.status = STAT_NOFREE;
              end
            end
            OP_RELEASE, OP_TEST, OP_RAW: begin
              if (idx_bad) begin
                done_d       = 1'b1;
                res_d.status = STAT_RANGE;
              end else begin
                map_raddr  = idx_ext[WordAw+4:5];
                sum_raddr  = idx_ext[SumAw+9:10];
                word_adr_d = idx_ext[WordAw+4:5];
                sum_adr_d  = idx_ext[SumAw+9:10];
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_AL_SUM: begin
        // A clear summary bit always exists here; the guard keeps a miss harmless.
        word_adr_d = {sum_adr_q, j_res[4:0]};
        map_raddr  = {sum_adr_q, j_res[4:0]};
        sum_word_d = sum_rdata;
        if (!j_res[5]) begin
          done_d = 1'b1;
          res_d  = '{result_block: '0, bit_read: 1'b0, free_count: count_q,
                     status: STAT_NOFREE};
        end
      end

      ST_AL_MAP: begin
        done_d = 1'b1;
        if (!b_res[5] || 17'(pick) >= total) begin
          res_d = '{result_block: '0, bit_read: 1'b0, free_count: count_q,
                    status: STAT_NOFREE};
        end else begin
          map_we  = 1'b1;
          sum_we  = 1'b1;
          top_d[sum_adr_q] = &alloc_sum;
          count_d = count_q - 17'd1;
          res_d   = '{result_block: 16'(pick), bit_read: 1'b0,
                      free_count: count_q - 17'd1, status: STAT_OK};
        end
      end

      ST_RMW: begin
        done_d = 1'b1;
        res_d  = '{result_block: '0, bit_read: 1'b0, free_count: count_q, status: STAT_OK};
        case (op_q)
          OP_TEST: begin
            res_d.bit_read = map_rdata[idx_q[4:0]];
          end
          OP_RELEASE, OP_RAW: begin
            map_we    = 1'b1;
            map_wdata = rmw_word;
            sum_we    = 1'b1;
            sum_wdata = rmw_sum;
            top_d[sum_adr_q] = &rmw_sum;
            if (op_q == OP_RELEASE) begin
              res_d.result_block = idx_q;
              if (count_q < total) begin
                count_d          = count_q + 17'd1;
                res_d.free_count = count_q + 17'd1;
              end
            end
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end

      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      sweep_q      <= '0;
      sweep_meta_q <= '0;
      fmt_q        <= 1'b0;
      count_q      <= '0;
      top_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      sweep_meta_q <= sweep_meta_d;
      fmt_q        <= fmt_d;
      count_q      <= count_d;
      top_q        <= top_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    op_q       <= op_d;
    idx_q      <= idx_d;
    bv_q       <= bv_d;
    word_adr_q <= word_adr_d;
    sum_adr_q  <= sum_adr_d;
    sum_word_q <= sum_word_d;
  end

  assign busy     = state_q != ST_IDLE;
  assign done_o   = done_q;
  assign result_o = res_q;

  `BBA_ASSERT_IMP(a_done_when_idle, clk_i, rst_ni, done_q, state_q == ST_IDLE,
    "result strobe outside idle")
  `BBA_ASSERT_NEXT(a_item_progress, clk_i, rst_ni, accept, done_q || state_q != ST_IDLE,
    "accepted item neither answered nor in work")
  `BBA_ASSERT_IMP(a_no_write_idle, clk_i, rst_ni, map_we || sum_we, state_q != ST_IDLE,
    "memory written while idle")
  `BBA_ASSERT_IMP(a_map_after_sum, clk_i, rst_ni, state_q == ST_AL_MAP,
    $past(state_q) == ST_AL_SUM, "map probe without summary probe")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for bitmap_block_allocator_top: drives format, allocate, release,
// test and raw-write items, predicts each answer with a bit-level map model and compares.
// Depends on bba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb;
  import bba_pkg::*;

  localparam int unsigned MAP_BITS    = bba_pkg::NBLOCKS_DEF;
  localparam int unsigned QUIET_LIMIT = 10000;
  localparam logic [2:0]  ADDR_TOTAL  = 3'd0;
  localparam logic [2:0]  ADDR_META   = 3'd4;
  // Opcodes that the block leaves undefined.
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  bba_in_t     item_i;
  logic        done_o;
  bba_out_t    result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Allocator state as the testbench sees it.
  bit          occ_map [MAP_BITS];
  logic [16:0] free_blocks;
  logic [16:0] cfg_total;
  logic [16:0] cfg_meta;

  bba_out_t    pending_answers [$];
  bit          gaps_on;
  int unsigned fails, n_sent, n_checked, n_formats, n_settings;
  int unsigned n_alloc_ok, n_no_free, n_out_of_range;
  int unsigned quiet_cycles;

  bitmap_block_allocator_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned block_limit();
    return (cfg_total > MAP_BITS) ? MAP_BITS : int'(cfg_total);
  endfunction

  // Applies one item to the map model and returns the answer the block must give.
  function automatic bba_out_t allocator_answer(input bba_in_t it);
    bba_out_t    r;
    int unsigned lim;
    int unsigned meta;
    int unsigned k;
    r        = '0;
    r.status = STAT_OK;
    lim      = block_limit();
    case (it.opcode)
      OP_FORMAT: begin
        meta = (cfg_meta > lim) ? lim : int'(cfg_meta);
        for (int b = 0; b < MAP_BITS; b++) occ_map[b] = (b < meta);
        free_blocks = 17'(lim - meta);
        n_formats++;
      end
      OP_ALLOC: begin
        k = lim;
        if (free_blocks != 0) begin
          k = 0;
          while (k < lim && occ_map[k]) k++;
        end
        if (k < lim) begin
          occ_map[k]     = 1'b1;
          free_blocks    = free_blocks - 17'd1;
          r.result_block = 16'(k);
          n_alloc_ok++;
        end else begin
          r.status = STAT_NOFREE;
          n_no_free++;
        end
      end
      OP_RELEASE, OP_TEST, OP_RAW: begin
        if (it.block_index >= lim) begin
          r.status = STAT_RANGE;
          n_out_of_range++;
        end else if (it.opcode == OP_RELEASE) begin
          occ_map[it.block_index] = 1'b0;
          if (free_blocks < lim) free_blocks = free_blocks + 17'd1;
          r.result_block = it.block_index;
        end else if (it.opcode == OP_TEST) begin
          r.bit_read = occ_map[it.block_index];
        end else begin
          occ_map[it.block_index] = it.bit_value;
        end
      end
      default: begin
      end
    endcase
    r.free_count = free_blocks;
    return r;
  endfunction

  task automatic send_op(input logic [2:0] op, input logic [15:0] idx, input logic bv);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start              <= 1'b1;
    item_i.opcode      <= op;
    item_i.block_index <= idx;
    item_i.bit_value   <= bv;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_answers.push_back(allocator_answer('{opcode: op, block_index: idx, bit_value: bv}));
    n_sent++;
  endtask

  // Waits until every answer is in and the block is quiet.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [16:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {15'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == ADDR_TOTAL) cfg_total = value;
    else cfg_meta = value;
    // Read the register straight back.
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {15'd0, value}) begin
      $error("prdata: expected %0d, actual %0d", value, prdata);
      fails++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly valid indices, some just past the end, some anywhere.
  function automatic logic [15:0] pick_index();
    int unsigned lim;
    int unsigned r;
    lim = block_limit();
    r   = $urandom_range(0, 99);
    if (r < 75 && lim > 0) return 16'($urandom_range(0, lim - 1));
    if (r < 88 && lim < MAP_BITS) return 16'(lim + $urandom_range(0, 3));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic send_random_item();
    int unsigned r;
    logic [2:0]  op;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_ALLOC;
    else if (r < 65) op = OP_RELEASE;
    else if (r < 80) op = OP_TEST;
    else if (r < 93) op = OP_RAW;
    else if (r < 95) op = OP_FORMAT;
    else op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    send_op(op, pick_index(), 1'($urandom_range(0, 1)));
  endtask

  // New map geometry, usually a fresh format, then a burst of random items.
  task automatic run_phase(input int unsigned n_items);
    int unsigned r;
    int unsigned lim;
    logic [16:0] tot;
    logic [16:0] meta;
    r = $urandom_range(0, 99);
    if (r < 55) tot = 17'($urandom_range(1, 96));
    else if (r < 75) tot = 17'($urandom_range(97, 2048));
    else if (r < 90) begin
      case ($urandom_range(0, 4))
        0:       tot = 17'd1;
        1:       tot = 17'd65536;
        2:       tot = 17'h1FFFF;
        3:       tot = 17'd65535;
        default: tot = 17'd0;
      endcase
    end else tot = 17'($urandom_range(0, 17'h1FFFF));
    lim = (tot > MAP_BITS) ? MAP_BITS : int'(tot);
    if ($urandom_range(0, 6) == 0) meta = 17'($urandom_range(0, 17'h1FFFF));
    else meta = 17'($urandom_range(0, lim));
    settle();
    write_reg(ADDR_TOTAL, tot);
    write_reg(ADDR_META, meta);
    n_settings++;
    // Now and then the old map is kept, so bits beyond a shrunken total survive.
    if ($urandom_range(0, 6) != 0) send_op(OP_FORMAT, 16'($urandom), 1'($urandom));
    repeat (n_items) send_random_item();
  endtask

  task automatic test_power_on();
    send_op(OP_ALLOC, 16'd0, 1'b0);
    send_op(OP_TEST, 16'd0, 1'b1);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      send_op(3'(op), 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_small_map();
    settle();
    write_reg(ADDR_TOTAL, 17'd4);
    write_reg(ADDR_META, 17'd1);
    n_settings++;
    send_op(OP_FORMAT, 16'd0, 1'b0);
    repeat (3) send_op(OP_ALLOC, 16'd0, 1'b0);
    send_op(OP_ALLOC, 16'd0, 1'b0);
    // Releasing a block that is already free still bumps the count.
    send_op(OP_RELEASE, 16'd2, 1'b0);
    send_op(OP_RELEASE, 16'd2, 1'b0);
    send_op(OP_RAW, 16'd2, 1'b1);
    // The count says two are free, yet no bit is clear.
    send_op(OP_ALLOC, 16'd0, 1'b0);
    repeat (3) send_op(OP_RELEASE, 16'd3, 1'b0);
    send_op(OP_TEST, 16'd3, 1'b0);
    send_op(OP_TEST, 16'd4, 1'b0);
    send_op(OP_RELEASE, 16'hFFFF, 1'b0);
    send_op(OP_RAW, 16'd4, 1'b1);
  endtask

  task automatic test_shrink_total();
    settle();
    write_reg(ADDR_TOTAL, 17'd2);
    send_op(OP_TEST, 16'd2, 1'b0);
    settle();
    write_reg(ADDR_TOTAL, 17'd4);
    n_settings++;
    send_op(OP_TEST, 16'd2, 1'b0);
  endtask

  task automatic test_full_map();
    settle();
    write_reg(ADDR_TOTAL, 17'h1FFFF);
    write_reg(ADDR_META, 17'd65535);
    n_settings++;
    send_op(OP_FORMAT, 16'd0, 1'b0);
    send_op(OP_ALLOC, 16'd0, 1'b0);
    send_op(OP_ALLOC, 16'd0, 1'b0);
    settle();
    write_reg(ADDR_META, 17'h1FFFF);
    send_op(OP_FORMAT, 16'hFFFF, 1'b1);
    send_op(OP_TEST, 16'hFFFF, 1'b0);
    settle();
    write_reg(ADDR_TOTAL, 17'd0);
    n_settings++;
    send_op(OP_ALLOC, 16'd0, 1'b0);
    send_op(OP_FORMAT, 16'd0, 1'b0);
  endtask

  task automatic test_random_phases();
    repeat (11) run_phase($urandom_range(40, 60));
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    run_phase(50);
    run_phase(50);
  endtask

  always @(posedge clk_i) begin : check_answers
    bba_out_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        $error("result with nothing pending: block %0d, status %0d",
               result_o.result_block, result_o.status);
        fails++;
      end else begin
        want = pending_answers.pop_front();
        n_checked++;
        if (result_o.result_block !== want.result_block) begin
          $error("result_block: expected %0d, actual %0d", want.result_block,
                 result_o.result_block);
          fails++;
        end
        if (result_o.bit_read !== want.bit_read) begin
          $error("bit_read: expected %0d, actual %0d", want.bit_read, result_o.bit_read);
          fails++;
        end
        if (result_o.free_count !== want.free_count) begin
          $error("free_count: expected %0d, actual %0d", want.free_count,
                 result_o.free_count);
          fails++;
        end
        if (result_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result_o.status);
          fails++;
        end
      end
    end
  end

  // Ends the run if neither an item nor a result moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d answers pending", quiet_cycles,
               pending_answers.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    quiet_cycles = 0;
    gaps_on      = 1'b1;
    free_blocks  = '0;
    cfg_total    = TOTAL_RST;
    cfg_meta     = META_RST;
    for (int b = 0; b < MAP_BITS; b++) occ_map[b] = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // The block clears its map after reset; items wait on busy.
    test_power_on();
    test_small_map();
    test_shrink_total();
    test_full_map();
    test_random_phases();
    test_back_to_back();
    settle();
    $display("Covered %0d items over %0d map settings and %0d formats; %0d answers checked.",
             n_sent, n_settings, n_formats, n_checked);
    $display("Allocations granted %0d, refused %0d; indices out of range %0d.",
             n_alloc_ok, n_no_free, n_out_of_range);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
